[sv/wtv_pkg.sv]
// ============================================================================
// wtv_pkg: shared types and constants of the windowed touch velocity block
// Event kind codes, stream payload widths and the command and status bundles
// that connect the controller to the datapath.
// ============================================================================
package wtv_pkg;

    // Touch event kinds carried in the input tuser field.
    typedef enum logic [1:0] {
        KIND_DOWN  = 2'd0,
        KIND_MOVE  = 2'd1,
        KIND_UP    = 2'd2,
        KIND_OTHER = 2'd3
    } kind_t;

    // Field widths fixed by the stream format.
    localparam int KIND_W   = 2;
    localparam int COORD_W  = 16;
    localparam int DTIME_W  = 16;
    localparam int VEL_W    = 32;
    localparam int COUNT_W  = 3;

    // Packed payload widths, padded to whole bytes.
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 72;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // accept an event and apply it to the history
        logic sum_step;   // add one history entry to the running sums
        logic scale;      // form scaled magnitudes and start the division
        logic div_step;   // one restoring division step on both axes
        logic finish;     // saturate and write the output register
    } wtv_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic sum_done;   // every held entry has been summed
        logic div_done;   // the current step is the last division step
        logic out_free;   // the output register can take a new result
    } wtv_stat_t;

endpackage

[sv/wtv_ctrl.sv]
// ============================================================================
// wtv_ctrl: sequencing controller of the windowed touch velocity block
// Walks each event through history update, summing, scaling, division and
// output, and issues one command bundle per cycle to the datapath.
// ============================================================================
module wtv_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  wtv_pkg::wtv_stat_t stat,
    output wtv_pkg::wtv_cmd_t  cmd
);
    import wtv_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_SCALE,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg, s_tready_next;

    // Next state and command decode.
    always_comb begin
        state_next    = state_reg;
        s_tready_next = s_tready_reg;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready_reg) begin
                    cmd.load      = 1'b1;
                    state_next    = ST_SUM;
                    s_tready_next = 1'b0;
                end
            end
            ST_SUM: begin
                if (stat.sum_done) begin
                    state_next = ST_SCALE;
                end else begin
                    cmd.sum_step = 1'b1;
                end
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.finish    = 1'b1;
                    state_next    = ST_IDLE;
                    s_tready_next = 1'b1;
                end
            end
            default: begin
                state_next    = ST_IDLE;
                s_tready_next = 1'b1;
            end
        endcase
    end

    // State and registered ready.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b1;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= s_tready_next;
        end
    end

    assign s_tready = s_tready_reg;

endmodule

[sv/wtv_dpath.sv]
// ============================================================================
// wtv_dpath: datapath of the windowed touch velocity block
// Holds the anchor and the delta history ring, sums the held entries one per
// cycle, scales by 16000 and divides both axes by the time sum bit-serially.
// ============================================================================
module wtv_dpath #(
    parameter int HISTORY_DEPTH = 5
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wtv_pkg::wtv_cmd_t             cmd,
    output wtv_pkg::wtv_stat_t            stat,
    input  logic [wtv_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [wtv_pkg::KIND_W-1:0]    s_tuser,
    output logic [wtv_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready
);
    import wtv_pkg::*;

    localparam int IDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int GROW   = $clog2(HISTORY_DEPTH);
    localparam int DX_W   = COORD_W + 1;
    localparam int SUMD_W = DX_W + GROW;
    localparam int SUMT_W = DTIME_W + GROW;
    localparam int MAG_W  = COORD_W + 14 + GROW;
    localparam int DIVC_W = $clog2(MAG_W);
    localparam int EXT_W  = ((MAG_W > VEL_W) ? MAG_W : VEL_W) + 1;
    localparam int PAD_W  = M_DATA_W - 2 * VEL_W - COUNT_W;

    // Unpacked input fields.
    kind_t               kind_in;
    logic [COORD_W-1:0]  pos_x_in;
    logic [COORD_W-1:0]  pos_y_in;
    logic [DTIME_W-1:0]  dtime_in;

    assign kind_in  = kind_t'(s_tuser);
    assign pos_x_in = s_tdata[COORD_W-1:0];
    assign pos_y_in = s_tdata[2*COORD_W-1:COORD_W];
    assign dtime_in = s_tdata[2*COORD_W+DTIME_W-1:2*COORD_W];

    // History ring, undefined until written.
    logic signed [DX_W-1:0]    hist_dx [HISTORY_DEPTH];
    logic signed [DX_W-1:0]    hist_dy [HISTORY_DEPTH];
    logic        [DTIME_W-1:0] hist_dt [HISTORY_DEPTH];
    logic                      hist_we;
    logic signed [DX_W-1:0]    new_dx, new_dy;

    // Control state.
    logic [IDX_W-1:0]   write_slot_reg, write_slot_next;
    logic [CNT_W-1:0]   filled_reg, filled_next;
    logic               anchor_valid_reg, anchor_valid_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [DIVC_W-1:0]  div_cnt_reg, div_cnt_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // Payload state.
    logic [COORD_W-1:0]       anchor_x_reg, anchor_x_next;
    logic [COORD_W-1:0]       anchor_y_reg, anchor_y_next;
    logic signed [SUMD_W-1:0] sum_x_reg, sum_x_next;
    logic signed [SUMD_W-1:0] sum_y_reg, sum_y_next;
    logic [SUMT_W-1:0]        sum_t_reg, sum_t_next;
    logic [MAG_W-1:0]         num_x_reg, num_x_next;
    logic [MAG_W-1:0]         num_y_reg, num_y_next;
    logic [SUMT_W-1:0]        rem_x_reg, rem_x_next;
    logic [SUMT_W-1:0]        rem_y_reg, rem_y_next;
    logic                     neg_x_reg, neg_x_next;
    logic                     neg_y_reg, neg_y_next;
    logic [M_DATA_W-1:0]      m_tdata_reg, m_tdata_next;

    // Scaling and division helpers.
    logic [SUMD_W-1:0] abs_x, abs_y;
    logic [MAG_W-1:0]  ext_x, ext_y;
    logic [SUMT_W:0]   shift_x, shift_y, den_ext;
    logic              ge_x, ge_y;
    logic [VEL_W-1:0]  vel_x, vel_y;
    logic              empty;

    // Truncated quotient magnitude to saturated signed velocity.
    function automatic logic [VEL_W-1:0] saturate(input logic [MAG_W-1:0] q,
                                                  input logic neg);
        logic [EXT_W-1:0] qx;
        logic [VEL_W-1:0] res;
        qx = EXT_W'(q);
        if (!neg) begin
            if (qx > EXT_W'({1'b0, {(VEL_W-1){1'b1}}})) begin
                res = {1'b0, {(VEL_W-1){1'b1}}};
            end else begin
                res = qx[VEL_W-1:0];
            end
        end else begin
            if (qx > EXT_W'({1'b1, {(VEL_W-1){1'b0}}})) begin
                res = {1'b1, {(VEL_W-1){1'b0}}};
            end else begin
                res = -qx[VEL_W-1:0];
            end
        end
        return res;
    endfunction

    assign new_dx  = $signed({1'b0, pos_x_in}) - $signed({1'b0, anchor_x_reg});
    assign new_dy  = $signed({1'b0, pos_y_in}) - $signed({1'b0, anchor_y_reg});
    assign abs_x   = sum_x_reg[SUMD_W-1] ? unsigned'(-sum_x_reg) : unsigned'(sum_x_reg);
    assign abs_y   = sum_y_reg[SUMD_W-1] ? unsigned'(-sum_y_reg) : unsigned'(sum_y_reg);
    assign ext_x   = MAG_W'(abs_x);
    assign ext_y   = MAG_W'(abs_y);
    assign den_ext = {1'b0, sum_t_reg};
    assign shift_x = {rem_x_reg, num_x_reg[MAG_W-1]};
    assign shift_y = {rem_y_reg, num_y_reg[MAG_W-1]};
    assign ge_x    = (shift_x >= den_ext);
    assign ge_y    = (shift_y >= den_ext);
    assign empty   = (filled_reg == '0);
    assign vel_x   = empty ? '0 : saturate(num_x_reg, neg_x_reg);
    assign vel_y   = empty ? '0 : saturate(num_y_reg, neg_y_reg);

    // Next-value logic for every command.
    always_comb begin
        write_slot_next   = write_slot_reg;
        filled_next       = filled_reg;
        anchor_valid_next = anchor_valid_reg;
        anchor_x_next     = anchor_x_reg;
        anchor_y_next     = anchor_y_reg;
        idx_next          = idx_reg;
        div_cnt_next      = div_cnt_reg;
        sum_x_next        = sum_x_reg;
        sum_y_next        = sum_y_reg;
        sum_t_next        = sum_t_reg;
        num_x_next        = num_x_reg;
        num_y_next        = num_y_reg;
        rem_x_next        = rem_x_reg;
        rem_y_next        = rem_y_reg;
        neg_x_next        = neg_x_reg;
        neg_y_next        = neg_y_reg;
        m_tdata_next      = m_tdata_reg;
        m_tvalid_next     = m_tvalid_reg;
        hist_we           = 1'b0;

        // Apply the event to the anchor and the history ring.
        if (cmd.load) begin
            idx_next   = '0;
            sum_x_next = '0;
            sum_y_next = '0;
            sum_t_next = '0;
            case (kind_in)
                KIND_DOWN: begin
                    write_slot_next   = '0;
                    filled_next       = '0;
                    anchor_x_next     = pos_x_in;
                    anchor_y_next     = pos_y_in;
                    anchor_valid_next = 1'b1;
                end
                KIND_MOVE: begin
                    if (dtime_in != '0) begin
                        if (anchor_valid_reg) begin
                            hist_we = 1'b1;
                            if (write_slot_reg == IDX_W'(HISTORY_DEPTH - 1)) begin
                                write_slot_next = '0;
                            end else begin
                                write_slot_next = write_slot_reg + 1'b1;
                            end
                            if (filled_reg != CNT_W'(HISTORY_DEPTH)) begin
                                filled_next = filled_reg + 1'b1;
                            end
                        end
                        anchor_x_next     = pos_x_in;
                        anchor_y_next     = pos_y_in;
                        anchor_valid_next = 1'b1;
                    end
                end
                KIND_UP: begin
                    anchor_valid_next = 1'b0;
                end
                default: begin
                end
            endcase
        end

        // Accumulate one held entry per cycle.
        if (cmd.sum_step) begin
            sum_x_next = sum_x_reg + SUMD_W'(hist_dx[idx_reg[IDX_W-1:0]]);
            sum_y_next = sum_y_reg + SUMD_W'(hist_dy[idx_reg[IDX_W-1:0]]);
            sum_t_next = sum_t_reg + SUMT_W'(hist_dt[idx_reg[IDX_W-1:0]]);
            idx_next   = idx_reg + 1'b1;
        end

        // Magnitude times 16000, built as 16384 - 256 - 128.
        if (cmd.scale) begin
            num_x_next   = (ext_x << 14) - (ext_x << 8) - (ext_x << 7);
            num_y_next   = (ext_y << 14) - (ext_y << 8) - (ext_y << 7);
            neg_x_next   = sum_x_reg[SUMD_W-1];
            neg_y_next   = sum_y_reg[SUMD_W-1];
            rem_x_next   = '0;
            rem_y_next   = '0;
            div_cnt_next = DIVC_W'(MAG_W - 1);
        end

        // Restoring division, quotient bits shift into the numerator.
        if (cmd.div_step) begin
            rem_x_next   = ge_x ? SUMT_W'(shift_x - den_ext) : shift_x[SUMT_W-1:0];
            rem_y_next   = ge_y ? SUMT_W'(shift_y - den_ext) : shift_y[SUMT_W-1:0];
            num_x_next   = {num_x_reg[MAG_W-2:0], ge_x};
            num_y_next   = {num_y_reg[MAG_W-2:0], ge_y};
            div_cnt_next = div_cnt_reg - 1'b1;
        end

        // Output register: load a result, or drain on a completed transaction.
        if (cmd.finish) begin
            m_tdata_next  = {{PAD_W{1'b0}}, COUNT_W'(filled_reg), vel_y, vel_x};
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_slot_reg   <= '0;
            filled_reg       <= '0;
            anchor_valid_reg <= 1'b0;
            anchor_x_reg     <= '0;
            anchor_y_reg     <= '0;
            idx_reg          <= '0;
            div_cnt_reg      <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            write_slot_reg   <= write_slot_next;
            filled_reg       <= filled_next;
            anchor_valid_reg <= anchor_valid_next;
            anchor_x_reg     <= anchor_x_next;
            anchor_y_reg     <= anchor_y_next;
            idx_reg          <= idx_next;
            div_cnt_reg      <= div_cnt_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        sum_x_reg   <= sum_x_next;
        sum_y_reg   <= sum_y_next;
        sum_t_reg   <= sum_t_next;
        num_x_reg   <= num_x_next;
        num_y_reg   <= num_y_next;
        rem_x_reg   <= rem_x_next;
        rem_y_reg   <= rem_y_next;
        neg_x_reg   <= neg_x_next;
        neg_y_reg   <= neg_y_next;
        m_tdata_reg <= m_tdata_next;
    end

    // History ring write port.
    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_dx[write_slot_reg] <= new_dx;
            hist_dy[write_slot_reg] <= new_dy;
            hist_dt[write_slot_reg] <= dtime_in;
        end
    end

    assign stat.sum_done = (idx_reg == filled_reg);
    assign stat.div_done = (div_cnt_reg == '0);
    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign m_tdata       = m_tdata_reg;
    assign m_tvalid      = m_tvalid_reg;

`ifndef SYNTHESIS
    // The fill count never exceeds the ring depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        filled_reg <= CNT_W'(HISTORY_DEPTH))
        else $error("history fill count above ring depth");

    // Until the ring wraps, the write slot equals the fill count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (filled_reg == CNT_W'(HISTORY_DEPTH)) || (filled_reg == CNT_W'(write_slot_reg)))
        else $error("write slot and fill count disagree");

    // A finished result is presented on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_tvalid_reg)
        else $error("finished result not presented");

    // The sum pass never reads past the held entries.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sum_step |-> (idx_reg < filled_reg))
        else $error("sum pass beyond held entries");
`endif

endmodule

[sv/windowed_touch_velocity.sv]
// ============================================================================
// windowed_touch_velocity: moving window touch velocity estimator
// Keeps the last deltas of a touch track and reports its velocity per event.
// ============================================================================
// Usage:
// - The input stream carries one touch event per transaction: s_tuser holds
//   the kind (down, move, up or cancel, other), s_tdata the position and the
//   time since the previous event in sixteenths of a millisecond.
// - The output stream returns exactly one transaction per event: x and y
//   velocity in pixels per second and the number of deltas in the window.
// - The block takes no new event until the result of the current one has
//   been written to the output register; s_tready returns high together
//   with m_tvalid. The time an event occupies the block grows with N, the
//   number of deltas held after the event, and is set by the one-entry-per-
//   cycle summing pass and the bit-serial divider, one quotient bit per cycle
//   over 30 + clog2(HISTORY_DEPTH) bits.
// - Reset clears the anchor and empties the window; s_tready is high after.
// - A stalled receiver holds the result in the output register; the block
//   takes and processes one more event meanwhile and then waits until the
//   held result has been taken.
// ============================================================================
module windowed_touch_velocity #(
    parameter int HISTORY_DEPTH = 5
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [15:0] pos_x, [31:16] pos_y, [47:32] delta_time
    input  logic [wtv_pkg::S_DATA_W-1:0]  s_tdata,
    // [1:0] kind
    input  logic [wtv_pkg::KIND_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] vel_x, [63:32] vel_y, [66:64] sample_count, [71:67] zero
    output logic [wtv_pkg::M_DATA_W-1:0]  m_tdata
);
    import wtv_pkg::*;

    wtv_cmd_t  cmd;
    wtv_stat_t stat;

    // Sequencing controller.
    wtv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // History, summing and division datapath.
    wtv_dpath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking testbench for windowed_touch_velocity
// Drives touch events into the input stream and predicts, for every accepted
// transaction, the velocity and window fill that the block must return. A
// directed sequence covers the event kinds and the corner cases. Random
// gestures follow: a down, a run of moves and an up, with some noise mixed
// in. Both stream sides idle at random, and the receiver holds off once for
// a long stretch so that the block backs up into its input.
// ============================================================================
module tb;
    import wtv_pkg::*;

    localparam int     HISTORY_DEPTH = 5;
    localparam int     VEL_SCALE     = 16000;
    localparam longint VEL_MAX       = 64'sd2147483647;
    localparam longint VEL_MIN       = -64'sd2147483648;
    localparam int     LIVE_TARGET   = 1050;
    localparam int     HOLD_AFTER    = 400;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     DRAIN_CYCLES  = 60;
    localparam int     CYCLE_LIMIT   = 1000000;

    // One touch event as it travels on the input stream.
    typedef struct packed {
        kind_t                kind;
        logic [COORD_W-1:0]   pos_x;
        logic [COORD_W-1:0]   pos_y;
        logic [DTIME_W-1:0]   delta_time;
    } touch_event_t;

    // One velocity report as it travels on the output stream.
    typedef struct packed {
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic [COUNT_W-1:0]      sample_count;
    } velocity_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata  = '0;
    logic [KIND_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;

    // Stimulus and expectation stores.
    touch_event_t pending_events[$];
    velocity_t    expected_vel[$];
    touch_event_t on_bus;
    int           events_sent  = 0;
    int           results_seen = 0;
    int           error_count  = 0;
    int           live_events  = 0;
    int           cycle_count  = 0;
    int           send_gap     = 0;
    int           recv_stall   = 0;
    logic         rx_hold      = 1'b0;

    // Shadow state of the velocity window.
    logic signed [COORD_W:0] win_dx[HISTORY_DEPTH];
    logic signed [COORD_W:0] win_dy[HISTORY_DEPTH];
    logic [DTIME_W-1:0]      win_dt[HISTORY_DEPTH];
    int                      win_slot;
    int                      win_fill;
    logic [COORD_W-1:0]      anchor_x;
    logic [COORD_W-1:0]      anchor_y;
    logic                    anchor_ok;

    always #10 aclk = ~aclk;

    windowed_touch_velocity #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Pixels per second from summed deltas, truncated toward zero and clamped.
    function automatic logic signed [VEL_W-1:0] scaled_rate(input longint sum_d,
                                                            input longint sum_t);
        longint q;
        if (sum_t <= 0)
            return '0;
        q = (sum_d * VEL_SCALE) / sum_t;
        if (q > VEL_MAX)
            q = VEL_MAX;
        if (q < VEL_MIN)
            q = VEL_MIN;
        return q[VEL_W-1:0];
    endfunction

    // Apply one event to the shadow window and return the velocity it reports.
    function automatic velocity_t track_touch_event(input touch_event_t ev);
        longint    sum_dx;
        longint    sum_dy;
        longint    sum_dt;
        velocity_t res;
        sum_dx = 0;
        sum_dy = 0;
        sum_dt = 0;
        case (ev.kind)
            KIND_DOWN: begin
                win_slot  = 0;
                win_fill  = 0;
                anchor_x  = ev.pos_x;
                anchor_y  = ev.pos_y;
                anchor_ok = 1'b1;
            end
            KIND_MOVE: begin
                // A move with no elapsed time is dropped entirely.
                if (ev.delta_time != '0) begin
                    if (anchor_ok) begin
                        win_dx[win_slot] = $signed({1'b0, ev.pos_x}) - $signed({1'b0, anchor_x});
                        win_dy[win_slot] = $signed({1'b0, ev.pos_y}) - $signed({1'b0, anchor_y});
                        win_dt[win_slot] = ev.delta_time;
                        win_slot = (win_slot + 1) % HISTORY_DEPTH;
                        if (win_fill < HISTORY_DEPTH)
                            win_fill++;
                    end
                    anchor_x  = ev.pos_x;
                    anchor_y  = ev.pos_y;
                    anchor_ok = 1'b1;
                end
            end
            KIND_UP: begin
                anchor_ok = 1'b0;
            end
            default: begin
            end
        endcase
        for (int i = 0; i < win_fill; i++) begin
            sum_dx += longint'(win_dx[i]);
            sum_dy += longint'(win_dy[i]);
            sum_dt += longint'(win_dt[i]);
        end
        res.vel_x        = (win_fill == 0) ? '0 : scaled_rate(sum_dx, sum_dt);
        res.vel_y        = (win_fill == 0) ? '0 : scaled_rate(sum_dy, sum_dt);
        res.sample_count = COUNT_W'(win_fill);
        return res;
    endfunction

    // Queue one event; ignored kinds and zero-time moves do not count as live.
    function automatic void add_event(input kind_t k, input int x, input int y,
                                      input int dt);
        touch_event_t ev;
        ev.kind       = k;
        ev.pos_x      = COORD_W'(x);
        ev.pos_y      = COORD_W'(y);
        ev.delta_time = DTIME_W'(dt);
        pending_events.push_back(ev);
        if (!(k == KIND_OTHER || (k == KIND_MOVE && ev.delta_time == '0)))
            live_events++;
    endfunction

    // Idle length: mostly none or short, a few long, none in calm phases.
    function automatic int pick_idle(input int phase);
        int r;
        r = $urandom_range(99);
        if ((phase / 128) % 4 == 1)
            return 0;
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(25, 60);
    endfunction

    // Input driver: feeds pending events and predicts each accepted transaction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_vel.push_back(track_touch_event(on_bus));
                events_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0 || pending_events.size() == 0) begin
                    if (send_gap > 0)
                        send_gap--;
                    s_tvalid <= 1'b0;
                end else begin
                    on_bus = pending_events.pop_front();
                    s_tdata  <= {on_bus.delta_time, on_bus.pos_y, on_bus.pos_x};
                    s_tuser  <= on_bus.kind;
                    s_tvalid <= 1'b1;
                    send_gap = pick_idle(events_sent);
                end
            end
        end
    end

    // Output monitor: checks each result transaction against the oldest prediction.
    always @(posedge aclk) begin : rx_monitor
        velocity_t got;
        velocity_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.vel_x        = m_tdata[VEL_W-1:0];
                got.vel_y        = m_tdata[2*VEL_W-1:VEL_W];
                got.sample_count = m_tdata[2*VEL_W+COUNT_W-1:2*VEL_W];
                if (expected_vel.size() == 0) begin
                    $error("result transaction with no event pending: vel_x %0d vel_y %0d",
                           got.vel_x, got.vel_y);
                    error_count++;
                end else begin
                    want = expected_vel.pop_front();
                    if (got.vel_x !== want.vel_x) begin
                        $error("vel_x: expected %0d, actual %0d", want.vel_x, got.vel_x);
                        error_count++;
                    end
                    if (got.vel_y !== want.vel_y) begin
                        $error("vel_y: expected %0d, actual %0d", want.vel_y, got.vel_y);
                        error_count++;
                    end
                    if (got.sample_count !== want.sample_count) begin
                        $error("sample_count: expected %0d, actual %0d",
                               want.sample_count, got.sample_count);
                        error_count++;
                    end
                    if (m_tdata[M_DATA_W-1:2*VEL_W+COUNT_W] !== '0) begin
                        $error("padding: expected 0, actual %0h",
                               m_tdata[M_DATA_W-1:2*VEL_W+COUNT_W]);
                        error_count++;
                    end
                end
                results_seen++;
            end
            if (rx_hold) begin
                m_tready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                recv_stall = pick_idle(results_seen);
            end
        end
    end

    // Long receiver hold-off so that the block fills and stalls its input.
    initial begin
        while (events_sent < HOLD_AFTER)
            @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // Watchdog on the whole run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $error("run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Stimulus build, reset and end of run.
    initial begin : stimulus
        int x;
        int y;
        int r;
        int dt;
        int moves;
        int total;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            win_dx[i] = '0;
            win_dy[i] = '0;
            win_dt[i] = '0;
        end
        win_slot  = 0;
        win_fill  = 0;
        anchor_x  = '0;
        anchor_y  = '0;
        anchor_ok = 1'b0;

        // Directed part: ignored kinds on an empty window, a move with no
        // anchor, extreme coordinates and times, ring wrap, history kept
        // across an up, zero-time moves, and a down that clears the window.
        add_event(KIND_OTHER, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_event(KIND_UP, 16'h0000, 16'h0000, 16'h0000);
        add_event(KIND_MOVE, 123, 456, 0);
        add_event(KIND_MOVE, 100, 200, 16);
        add_event(KIND_MOVE, 0, 0, 1);
        add_event(KIND_MOVE, 16'hFFFF, 16'hFFFF, 1);
        add_event(KIND_MOVE, 16'hFFFF, 0, 16'hFFFF);
        add_event(KIND_MOVE, 0, 16'hFFFF, 16'h8000);
        add_event(KIND_MOVE, 16'hAAAA, 16'h5555, 3);
        add_event(KIND_MOVE, 16'h5555, 16'hAAAA, 7);
        add_event(KIND_MOVE, 16'h5556, 16'hAAA9, 1);
        add_event(KIND_MOVE, 16'h5555, 16'hAAAA, 0);
        add_event(KIND_UP, 16'h1234, 16'h4321, 16'h00FF);
        add_event(KIND_MOVE, 0, 0, 16'h7FFF);
        add_event(KIND_MOVE, 16'hFFFF, 16'hFFFF, 1);
        add_event(KIND_OTHER, 16'h0F0F, 16'hF0F0, 16'h00F0);
        add_event(KIND_DOWN, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_event(KIND_MOVE, 0, 0, 1);
        add_event(KIND_DOWN, 0, 0, 0);
        add_event(KIND_MOVE, 1, 16'hFFFF, 2);

        // Random part: mostly well-formed gestures with random content.
        while (live_events < LIVE_TARGET) begin
            if ($urandom_range(9) == 0) begin
                add_event(kind_t'($urandom_range(3)), $urandom, $urandom, $urandom);
            end else begin
                x = $urandom_range(65535);
                y = $urandom_range(65535);
                add_event(KIND_DOWN, x, y, $urandom_range(65535));
                moves = $urandom_range(1, 12);
                for (int m = 0; m < moves; m++) begin
                    r = $urandom_range(99);
                    if (r < 8) begin
                        x = $urandom_range(65535);
                        y = $urandom_range(65535);
                    end else begin
                        x = x + $urandom_range(80) - 40;
                        y = y + $urandom_range(80) - 40;
                    end
                    r = $urandom_range(99);
                    if (r < 5)
                        dt = 0;
                    else if (r < 15)
                        dt = $urandom_range(65535);
                    else
                        dt = $urandom_range(1, 320);
                    add_event(KIND_MOVE, x, y, dt);
                    // Occasional lift or stray event inside the gesture.
                    r = $urandom_range(99);
                    if (r < 8)
                        add_event(KIND_UP, $urandom, $urandom, $urandom);
                    else if (r < 12)
                        add_event(KIND_OTHER, $urandom, $urandom, $urandom);
                end
                if ($urandom_range(3) != 0)
                    add_event(KIND_UP, x, y, $urandom_range(65535));
            end
        end
        total = pending_events.size();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (events_sent < total)
            @(posedge aclk);
        while (expected_vel.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
sv/wtv_pkg.sv
sv/wtv_ctrl.sv
sv/wtv_dpath.sv
sv/windowed_touch_velocity.sv
tb/tb.sv
